// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Needs a clock and a reset signal in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define GSS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define GSS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/gss_pkg.sv =====
// Types and constants for the Gray-Scott grid stepper.
// No dependencies.
package gss_pkg;

   typedef struct packed {
      logic [1:0] command;
      logic [6:0] x_coord;
      logic [5:0] y_coord;
      logic [3:0] radius;
      logic       erase;
   } req_type;

   typedef struct packed {
      logic [15:0] cell_a;
      logic [15:0] cell_b;
      logic [13:0] active_count;
      logic [28:0] b_sum;
   } rsp_type;

   // Cell word: b in the upper half, a in the lower half.
   typedef struct packed {
      logic [15:0] b;
      logic [15:0] a;
   } cell_type;

   localparam logic [1:0] CMD_INJECT = 2'd0;
   localparam logic [1:0] CMD_STEP   = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   localparam logic [2:0] CSR_FEED      = 3'd0;
   localparam logic [2:0] CSR_KILL      = 3'd1;
   localparam logic [2:0] CSR_DIFF_A    = 3'd2;
   localparam logic [2:0] CSR_DIFF_B    = 3'd3;
   localparam logic [2:0] CSR_THRESHOLD = 3'd4;

   localparam logic [15:0] Q15_ONE = 16'd32768;
   localparam logic [15:0] SEED_A  = 16'd4915;

   localparam logic [15:0] FEED_RESET      = 16'd1802;
   localparam logic [15:0] KILL_RESET      = 16'd2032;
   localparam logic [15:0] DIFF_A_RESET    = 16'd32768;
   localparam logic [15:0] DIFF_B_RESET    = 16'd16384;
   localparam logic [15:0] THRESHOLD_RESET = 16'd3932;

   localparam cell_type CELL_INIT = '{b: 16'd0, a: Q15_ONE};

endpackage

// ===== hdl/gray_scott_grid_step.sv =====
// Gray-Scott reaction-diffusion grid stepper, toroidal W x H grid, two banks of cells.
// Generation: reads the (H+2) x (W+2) extended grid (one port, one cell a cycle), then drains.
// Inject: wraps the corner, then walks the (2r+1)^2 square; read: wraps, then reads the bank.
// Sync active-high reset; a clearing pass over all W*H cells fills both banks with a=1, b=0
// while req_stall stays high. Configuration writes are taken at any time.
module gray_scott_grid_step
   import gss_pkg::*;
#(
   parameter int GRID_WIDTH  = 128,
   parameter int GRID_HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
   localparam int AW    = $clog2(CELLS);
   localparam int XW    = $clog2(GRID_WIDTH);
   localparam int YW    = $clog2(GRID_HEIGHT);
   localparam int EXW   = $clog2(GRID_WIDTH + 2);
   localparam int EYW   = $clog2(GRID_HEIGHT + 2);
   localparam int CW    = (XW > YW) ? XW : YW;
   localparam int PW    = ((CW > 7) ? CW : 7) + 2;   // signed wrap arithmetic
   localparam int NW    = 58;                        // numerator width
   localparam int QS    = 30;                        // 2^30 part of the denominator
   localparam int MW    = NW - QS;
   localparam int DEN_MUL    = 20;                   // denominator is 20 * 2^30
   localparam int LAP_CENTRE = 20;
   localparam int CAP_LIMIT  = 20 * 32769;           // quotient above 1.0
   localparam int RECIP_FIVE = 52429;                // 2^18 / 5, rounded up
   localparam logic signed [NW-1:0] ROUND_BIAS = NW'(10) <<< QS;

   // Sequencer states
   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_PREP   = 4'd2;
   localparam logic [3:0] ST_DISC   = 4'd3;
   localparam logic [3:0] ST_READ   = 4'd4;
   localparam logic [3:0] ST_RDWAIT = 4'd5;
   localparam logic [3:0] ST_GEN    = 4'd6;
   localparam logic [3:0] ST_DRAIN  = 4'd7;
   localparam logic [3:0] ST_DONE   = 4'd8;

   // ------------------------------------------------------------------
   // Control and configuration state
   // ------------------------------------------------------------------
   logic [3:0]  state_ff;
   logic        live_ff;           // bank holding the current generation
   logic [13:0] active_total_ff;
   logic [28:0] b_total_ff;
   logic [15:0] feed_ff, kill_ff, diff_a_ff, diff_b_ff, thresh_ff;
   logic [AW-1:0] clr_ff;

   // Command context
   logic [1:0]  cmd_ff;
   logic        erase_ff;
   logic [3:0]  rad_ff;
   logic signed [PW-1:0] xs_ff, ys_ff;   // disc corner, wrapped during prep
   logic [XW-1:0] xp_ff, x0_ff;
   logic [YW-1:0] yp_ff;
   logic signed [4:0] dx_ff, dy_ff;

   // Generation sweep over the extended (H+2) x (W+2) grid
   logic [EYW-1:0] er_ff;
   logic [EXW-1:0] ec_ff;

   // Result path
   logic [15:0] pend_a_ff, pend_b_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;
   logic        rsp_load;

   // ------------------------------------------------------------------
   // Memories: two cell banks and a two-row line buffer
   // ------------------------------------------------------------------
   cell_type    bank0_mem [CELLS];
   cell_type    bank1_mem [CELLS];
   cell_type    bank0_q_ff, bank1_q_ff;
   logic [63:0] lbuf_mem [GRID_WIDTH + 2];
   logic [63:0] lbuf_q_ff;

   logic [AW-1:0] rd_addr, wr_addr, disc_addr, gen_addr;
   cell_type      wr_data;
   logic          we0, we1;
   cell_type      live_q;

   // ------------------------------------------------------------------
   // Stencil pipeline
   // ------------------------------------------------------------------
   logic           s1_vld_ff;
   logic [EYW-1:0] s1_er_ff;
   logic [EXW-1:0] s1_ec_ff;
   cell_type       win_ff [3][3];         // [row][col], col 2 newest
   logic           wv_ff;
   logic [AW-1:0]  wv_addr_ff;

   logic           st1_vld_ff;
   logic [AW-1:0]  st1_addr_ff;
   logic [15:0]    st1_ca_ff, st1_cb_ff;
   logic signed [22:0] st1_lapa_ff, st1_lapb_ff;

   logic           st2_vld_ff;
   logic [AW-1:0]  st2_addr_ff;
   logic [15:0]    st2_ca_ff, st2_cb_ff;
   logic [31:0]    st2_ab_ff;
   logic signed [39:0] st2_pda_ff, st2_pdb_ff;
   logic signed [33:0] st2_pf_ff;
   logic [32:0]    st2_kb_ff;

   logic           st3_vld_ff;
   logic [AW-1:0]  st3_addr_ff;
   logic [15:0]    st3_ca_ff, st3_cb_ff;
   logic [47:0]    st3_abb_ff;
   logic signed [39:0] st3_pda_ff, st3_pdb_ff;
   logic signed [33:0] st3_pf_ff;
   logic [32:0]    st3_kb_ff;

   logic           st4_vld_ff;
   logic [AW-1:0]  st4_addr_ff;
   logic signed [NW-1:0] st4_sa_a_ff, st4_sb_a_ff, st4_sa_b_ff, st4_sb_b_ff;

   logic           st5_vld_ff;
   logic [AW-1:0]  st5_addr_ff;
   logic signed [NW-1:0] st5_na_ff, st5_nb_ff;

   logic           st6_vld_ff;
   logic [AW-1:0]  st6_addr_ff;
   logic           st6_pos_a_ff, st6_pos_b_ff, st6_cap_a_ff, st6_cap_b_ff;
   logic [17:0]    st6_xa_ff, st6_xb_ff;

   logic           st7_vld_ff;
   logic [AW-1:0]  st7_addr_ff;
   logic [15:0]    st7_ra_ff, st7_rb_ff;

   logic [13:0]    acc_act_ff;
   logic [28:0]    acc_sum_ff;

   // 9-point Laplacian times 20: 4*sides + corners - 20*centre
   function automatic logic signed [22:0] lap_calc(
      input logic [15:0] n, input logic [15:0] s, input logic [15:0] w,
      input logic [15:0] e, input logic [15:0] nw, input logic [15:0] ne,
      input logic [15:0] sw, input logic [15:0] se, input logic [15:0] c);
      logic [17:0] side;
      logic [17:0] corner;
      logic [20:0] pos;
      logic [20:0] neg;
      side   = 18'(n) + 18'(s) + 18'(w) + 18'(e);
      corner = 18'(nw) + 18'(ne) + 18'(sw) + 18'(se);
      pos    = (21'(side) << 2) + 21'(corner);
      neg    = 21'(c) * 21'(LAP_CENTRE);
      return $signed(23'(pos)) - $signed(23'(neg));
   endfunction

   // ------------------------------------------------------------------
   // Address generation
   // ------------------------------------------------------------------
   logic [YW-1:0] gen_gy;
   logic [XW-1:0] gen_gx;
   logic          disc_inside;
   logic signed [9:0] dx_sq, dy_sq, dist_sq;
   logic [7:0]    rad_sq;
   logic          xs_ok, ys_ok;

   always_comb begin
      // Extended row 0 and row H+1 fetch the wrapped neighbor rows.
      if (er_ff == '0) begin
         gen_gy = YW'(GRID_HEIGHT - 1);
      end else if (er_ff == EYW'(GRID_HEIGHT + 1)) begin
         gen_gy = '0;
      end else begin
         gen_gy = YW'(er_ff - EYW'(1));
      end
      if (ec_ff == '0) begin
         gen_gx = XW'(GRID_WIDTH - 1);
      end else if (ec_ff == EXW'(GRID_WIDTH + 1)) begin
         gen_gx = '0;
      end else begin
         gen_gx = XW'(ec_ff - EXW'(1));
      end
      gen_addr  = AW'(gen_gy) * AW'(GRID_WIDTH) + AW'(gen_gx);
      disc_addr = AW'(yp_ff) * AW'(GRID_WIDTH) + AW'(xp_ff);

      dx_sq   = 10'(dx_ff) * 10'(dx_ff);
      dy_sq   = 10'(dy_ff) * 10'(dy_ff);
      dist_sq = dx_sq + dy_sq;
      rad_sq  = 8'(rad_ff) * 8'(rad_ff);
      disc_inside = dist_sq <= $signed({2'b00, rad_sq});

      xs_ok = !xs_ff[PW-1] && (xs_ff < $signed(PW'(GRID_WIDTH)));
      ys_ok = !ys_ff[PW-1] && (ys_ff < $signed(PW'(GRID_HEIGHT)));
   end

   // Bank ports: reads always come from the live bank; generation writes the other.
   always_comb begin
      rd_addr = (state_ff == ST_GEN) ? gen_addr : disc_addr;
      live_q  = live_ff ? bank1_q_ff : bank0_q_ff;
      we0     = 1'b0;
      we1     = 1'b0;
      wr_addr = st7_addr_ff;
      wr_data = '{b: st7_rb_ff, a: st7_ra_ff};
      if (state_ff == ST_CLEAR) begin
         we0     = 1'b1;
         we1     = 1'b1;
         wr_addr = clr_ff;
         wr_data = CELL_INIT;
      end else if (state_ff == ST_DISC && disc_inside) begin
         we0     = !live_ff;
         we1     = live_ff;
         wr_addr = disc_addr;
         wr_data = erase_ff ? CELL_INIT : '{b: Q15_ONE, a: SEED_A};
      end else if (st7_vld_ff) begin
         we0     = live_ff;
         we1     = !live_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we0) begin
         bank0_mem[wr_addr] <= wr_data;
      end
      bank0_q_ff <= bank0_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (we1) begin
         bank1_mem[wr_addr] <= wr_data;
      end
      bank1_q_ff <= bank1_mem[rd_addr];
   end

   // Line buffer entry per extended column: {row er-2, row er-1}
   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         lbuf_mem[s1_ec_ff] <= {lbuf_q_ff[31:0], live_q};
      end
      lbuf_q_ff <= lbuf_mem[ec_ff];
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   assign req_stall    = (state_ff != ST_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_load     = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_ff          <= '0;
         live_ff         <= 1'b0;
         active_total_ff <= '0;
         b_total_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
         feed_ff         <= FEED_RESET;
         kill_ff         <= KILL_RESET;
         diff_a_ff       <= DIFF_A_RESET;
         diff_b_ff       <= DIFF_B_RESET;
         thresh_ff       <= THRESHOLD_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FEED:      feed_ff   <= csr_data;
               CSR_KILL:      kill_ff   <= csr_data;
               CSR_DIFF_A:    diff_a_ff <= csr_data;
               CSR_DIFF_B:    diff_b_ff <= csr_data;
               CSR_THRESHOLD: thresh_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(CELLS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  case (req_data.command)
                     CMD_INJECT, CMD_READ: state_ff <= ST_PREP;
                     CMD_STEP:             state_ff <= ST_GEN;
                     default:              state_ff <= ST_DONE;
                  endcase
               end
            end
            ST_PREP: begin
               if (xs_ok && ys_ok) begin
                  state_ff <= (cmd_ff == CMD_INJECT) ? ST_DISC : ST_READ;
               end
            end
            ST_DISC: begin
               if (dx_ff == $signed({1'b0, rad_ff}) && dy_ff == $signed({1'b0, rad_ff})) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_READ:   state_ff <= ST_RDWAIT;
            ST_RDWAIT: state_ff <= ST_DONE;
            ST_GEN: begin
               if (er_ff == EYW'(GRID_HEIGHT + 1) && ec_ff == EXW'(GRID_WIDTH + 1)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               // Last cell written and counted: publish and swap banks.
               if (!(s1_vld_ff || wv_ff || st1_vld_ff || st2_vld_ff || st3_vld_ff ||
                     st4_vld_ff || st5_vld_ff || st6_vld_ff || st7_vld_ff)) begin
                  live_ff         <= !live_ff;
                  active_total_ff <= acc_act_ff;
                  b_total_ff      <= acc_sum_ff;
                  state_ff        <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Command context, wrap, disc walk and sweep counters
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            cmd_ff    <= req_data.command;
            erase_ff  <= req_data.erase;
            rad_ff    <= (req_data.command == CMD_INJECT) ? req_data.radius : 4'd0;
            xs_ff     <= $signed(PW'(req_data.x_coord)) -
                         $signed(PW'((req_data.command == CMD_INJECT) ? req_data.radius : 4'd0));
            ys_ff     <= $signed(PW'(req_data.y_coord)) -
                         $signed(PW'((req_data.command == CMD_INJECT) ? req_data.radius : 4'd0));
            pend_a_ff <= '0;
            pend_b_ff <= '0;
            er_ff     <= '0;
            ec_ff     <= '0;
         end
         ST_PREP: begin
            // One correction a cycle per axis until both lie on the torus.
            if (xs_ff[PW-1]) begin
               xs_ff <= xs_ff + $signed(PW'(GRID_WIDTH));
            end else if (!xs_ok) begin
               xs_ff <= xs_ff - $signed(PW'(GRID_WIDTH));
            end
            if (ys_ff[PW-1]) begin
               ys_ff <= ys_ff + $signed(PW'(GRID_HEIGHT));
            end else if (!ys_ok) begin
               ys_ff <= ys_ff - $signed(PW'(GRID_HEIGHT));
            end
            xp_ff <= XW'(xs_ff);
            x0_ff <= XW'(xs_ff);
            yp_ff <= YW'(ys_ff);
            dx_ff <= -$signed({1'b0, rad_ff});
            dy_ff <= -$signed({1'b0, rad_ff});
         end
         ST_DISC: begin
            if (dx_ff == $signed({1'b0, rad_ff})) begin
               dx_ff <= -$signed({1'b0, rad_ff});
               xp_ff <= x0_ff;
               dy_ff <= dy_ff + 5'sd1;
               yp_ff <= (yp_ff == YW'(GRID_HEIGHT - 1)) ? '0 : yp_ff + YW'(1);
            end else begin
               dx_ff <= dx_ff + 5'sd1;
               xp_ff <= (xp_ff == XW'(GRID_WIDTH - 1)) ? '0 : xp_ff + XW'(1);
            end
         end
         ST_RDWAIT: begin
            pend_a_ff <= live_q.a;
            pend_b_ff <= live_q.b;
         end
         ST_GEN: begin
            if (ec_ff == EXW'(GRID_WIDTH + 1)) begin
               ec_ff <= '0;
               er_ff <= er_ff + EYW'(1);
            end else begin
               ec_ff <= ec_ff + EXW'(1);
            end
         end
         default: ;
      endcase
      if (rsp_load) begin
         rsp_data_ff <= '{cell_a: pend_a_ff, cell_b: pend_b_ff,
                          active_count: active_total_ff, b_sum: b_total_ff};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Stencil pipeline valids and totals
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         wv_ff      <= 1'b0;
         st1_vld_ff <= 1'b0;
         st2_vld_ff <= 1'b0;
         st3_vld_ff <= 1'b0;
         st4_vld_ff <= 1'b0;
         st5_vld_ff <= 1'b0;
         st6_vld_ff <= 1'b0;
         st7_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= (state_ff == ST_GEN);
         // Window is complete once two rows and two columns have streamed in.
         wv_ff      <= s1_vld_ff && (s1_er_ff >= EYW'(2)) && (s1_ec_ff >= EXW'(2));
         st1_vld_ff <= wv_ff;
         st2_vld_ff <= st1_vld_ff;
         st3_vld_ff <= st2_vld_ff;
         st4_vld_ff <= st3_vld_ff;
         st5_vld_ff <= st4_vld_ff;
         st6_vld_ff <= st5_vld_ff;
         st7_vld_ff <= st6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         acc_act_ff <= '0;
         acc_sum_ff <= '0;
      end else if (st7_vld_ff) begin
         acc_act_ff <= acc_act_ff + 14'(st7_rb_ff > thresh_ff);
         acc_sum_ff <= acc_sum_ff + 29'(st7_rb_ff);
      end
   end

   // ------------------------------------------------------------------
   // Stencil pipeline datapath
   // ------------------------------------------------------------------
   logic [15:0] pipe_ca, pipe_cb;
   logic signed [16:0] feed_gap;
   logic [20:0] ca20, cb20;
   logic [52:0] abb20;
   logic signed [39:0] pf20;
   logic [37:0] kb20;
   logic signed [NW-1:0] ta0, ta1, ta3, tb0, tb1, tb3, tab;
   logic signed [NW-1:0] rnd_a, rnd_b;
   logic [MW-1:0] m_a, m_b;
   logic [34:0] qa_prod, qb_prod;

   always_comb begin
      pipe_ca  = st1_ca_ff;
      pipe_cb  = st1_cb_ff;
      feed_gap = $signed(17'(Q15_ONE) - 17'(pipe_ca));
      ca20  = 21'(st3_ca_ff) * 21'(DEN_MUL);
      cb20  = 21'(st3_cb_ff) * 21'(DEN_MUL);
      abb20 = 53'(st3_abb_ff) * 53'(DEN_MUL);
      pf20  = 40'(st3_pf_ff) * $signed(40'(DEN_MUL));
      kb20  = 38'(st3_kb_ff) * 38'(DEN_MUL);
      ta0   = $signed(NW'(ca20)) <<< QS;
      ta1   = NW'(st3_pda_ff) <<< 15;
      ta3   = NW'(pf20) <<< 15;
      tb0   = $signed(NW'(cb20)) <<< QS;
      tb1   = NW'(st3_pdb_ff) <<< 15;
      tb3   = $signed(NW'(kb20)) <<< 15;
      tab   = $signed(NW'(abb20));
      rnd_a = st5_na_ff + ROUND_BIAS;
      rnd_b = st5_nb_ff + ROUND_BIAS;
      m_a   = rnd_a[NW-1:QS];
      m_b   = rnd_b[NW-1:QS];
      // q / 20 = (q / 4) / 5; reciprocal is exact below the cap
      qa_prod = 35'(st6_xa_ff) * 35'(RECIP_FIVE);
      qb_prod = 35'(st6_xb_ff) * 35'(RECIP_FIVE);
   end

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= lbuf_q_ff[63:32];
         win_ff[1][2] <= lbuf_q_ff[31:0];
         win_ff[2][2] <= live_q;
      end
      s1_er_ff   <= er_ff;
      s1_ec_ff   <= ec_ff;
      wv_addr_ff <= AW'(YW'(s1_er_ff - EYW'(2))) * AW'(GRID_WIDTH) +
                    AW'(XW'(s1_ec_ff - EXW'(2)));

      // Laplacians
      st1_addr_ff <= wv_addr_ff;
      st1_ca_ff   <= win_ff[1][1].a;
      st1_cb_ff   <= win_ff[1][1].b;
      st1_lapa_ff <= lap_calc(win_ff[0][1].a, win_ff[2][1].a, win_ff[1][0].a,
                              win_ff[1][2].a, win_ff[0][0].a, win_ff[0][2].a,
                              win_ff[2][0].a, win_ff[2][2].a, win_ff[1][1].a);
      st1_lapb_ff <= lap_calc(win_ff[0][1].b, win_ff[2][1].b, win_ff[1][0].b,
                              win_ff[1][2].b, win_ff[0][0].b, win_ff[0][2].b,
                              win_ff[2][0].b, win_ff[2][2].b, win_ff[1][1].b);

      // First products
      st2_addr_ff <= st1_addr_ff;
      st2_ca_ff   <= pipe_ca;
      st2_cb_ff   <= pipe_cb;
      st2_ab_ff   <= 32'(pipe_ca) * 32'(pipe_cb);
      st2_pda_ff  <= 40'($signed({1'b0, diff_a_ff})) * 40'(st1_lapa_ff);
      st2_pdb_ff  <= 40'($signed({1'b0, diff_b_ff})) * 40'(st1_lapb_ff);
      st2_pf_ff   <= 34'($signed({1'b0, feed_ff})) * 34'(feed_gap);
      st2_kb_ff   <= (33'(kill_ff) + 33'(feed_ff)) * 33'(pipe_cb);

      // Reaction term a*b*b
      st3_addr_ff <= st2_addr_ff;
      st3_ca_ff   <= st2_ca_ff;
      st3_cb_ff   <= st2_cb_ff;
      st3_abb_ff  <= 48'(st2_ab_ff) * 48'(st2_cb_ff);
      st3_pda_ff  <= st2_pda_ff;
      st3_pdb_ff  <= st2_pdb_ff;
      st3_pf_ff   <= st2_pf_ff;
      st3_kb_ff   <= st2_kb_ff;

      // Numerators in two adds
      st4_addr_ff <= st3_addr_ff;
      st4_sa_a_ff <= ta0 + ta1;
      st4_sb_a_ff <= ta3 - tab;
      st4_sa_b_ff <= tb0 + tb1;
      st4_sb_b_ff <= tab - tb3;

      st5_addr_ff <= st4_addr_ff;
      st5_na_ff   <= st4_sa_a_ff + st4_sb_a_ff;
      st5_nb_ff   <= st4_sa_b_ff + st4_sb_b_ff;

      // Round half up, drop 2^30, flag saturation
      st6_addr_ff  <= st5_addr_ff;
      st6_pos_a_ff <= st5_na_ff > 0;
      st6_pos_b_ff <= st5_nb_ff > 0;
      st6_cap_a_ff <= m_a >= MW'(CAP_LIMIT);
      st6_cap_b_ff <= m_b >= MW'(CAP_LIMIT);
      st6_xa_ff    <= m_a[19:2];
      st6_xb_ff    <= m_b[19:2];

      st7_addr_ff <= st6_addr_ff;
      st7_ra_ff   <= !st6_pos_a_ff ? 16'd0 : (st6_cap_a_ff ? Q15_ONE : qa_prod[33:18]);
      st7_rb_ff   <= !st6_pos_b_ff ? 16'd0 : (st6_cap_b_ff ? Q15_ONE : qb_prod[33:18]);
   end

endmodule

// ===== hdl/gss_checker.sv =====
// Port-level checks for the Gray-Scott grid stepper, bound to the top level.
// Depends on gss_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gss_checker
   import gss_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // Transactions taken but not yet answered
   logic [1:0] outstanding_ff, outstanding_in;

   always_comb begin
      outstanding_in = outstanding_ff + 2'(req_valid && !req_stall)
                       - 2'(rsp_valid && !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   `GSS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result changed while stalled")
   `GSS_ASSERT_NOW(a_rsp_has_req, rsp_valid, outstanding_ff != 2'd0, "result without a request")
   `GSS_ASSERT_NOW(a_depth, 1'b1, outstanding_ff != 2'd3, "more than two transactions in flight")
   `GSS_ASSERT_NOW(a_range, rsp_valid, rsp_data.cell_a <= Q15_ONE && rsp_data.cell_b <= Q15_ONE, "cell value above one")
   `GSS_ASSERT_NOW(a_clear, $past(reset), req_stall && !rsp_valid, "request taken during clearing pass")

endmodule

bind gray_scott_grid_step gss_checker u_gss_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for gray_scott_grid_step: inject, step and read transactions
// are checked against an in-bench Gray-Scott predictor. Depends on gss_pkg and the RTL.
module testbench;
   import gss_pkg::*;

   localparam int WIDTH      = 128;
   localparam int HEIGHT     = 64;
   localparam int CELLS      = WIDTH * HEIGHT;
   localparam int CYCLE_CAP  = 4000000;
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   always #10 clock = ~clock;

   gray_scott_grid_step #(.GRID_WIDTH(WIDTH), .GRID_HEIGHT(HEIGHT)) dut (.*);

   // Predictor state: one live grid is enough, the banks only alternate.
   cell_type    grid_live [CELLS];
   cell_type    grid_next [CELLS];
   logic [15:0] feed_q, kill_q, diff_a_q, diff_b_q, thresh_q;
   logic [13:0] active_q;
   logic [28:0] bsum_q;

   rsp_type     expected_rsp[$];
   int          mismatches = 0;
   int          cycles = 0;
   bit          hold_rsp = 1'b0;   // long receiver hold-off
   bit          stim_done = 1'b0;

   function automatic logic [15:0] settle(longint num, longint den);
      longint q;
      if (num <= 0) return 16'd0;
      q = (num + den / 2) / den;
      return (q > 32768) ? 16'd32768 : q[15:0];
   endfunction

   function automatic int cell_at(int x, int y);
      return (((y % HEIGHT) + HEIGHT) % HEIGHT) * WIDTH + (((x % WIDTH) + WIDTH) % WIDTH);
   endfunction

   task automatic run_generation();
      longint den, ca, cb, la, lb, react, na, nb, f, k;
      int      act, x, y, i;
      logic [31:0] total;
      logic [15:0] ra, rb;
      cell_type s[9];
      den = longint'(20) << 30;
      f = feed_q; k = kill_q;
      act = 0; total = 0;
      for (y = 0; y < HEIGHT; y++)
         for (x = 0; x < WIDTH; x++) begin
            // sides, then corners, then center
            s[0] = grid_live[cell_at(x - 1, y)];
            s[1] = grid_live[cell_at(x + 1, y)];
            s[2] = grid_live[cell_at(x, y - 1)];
            s[3] = grid_live[cell_at(x, y + 1)];
            s[4] = grid_live[cell_at(x - 1, y - 1)];
            s[5] = grid_live[cell_at(x + 1, y - 1)];
            s[6] = grid_live[cell_at(x - 1, y + 1)];
            s[7] = grid_live[cell_at(x + 1, y + 1)];
            s[8] = grid_live[cell_at(x, y)];
            ca = s[8].a; cb = s[8].b;
            la = -20 * ca; lb = -20 * cb;
            for (i = 0; i < 8; i++) begin
               la += (i < 4) ? 4 * longint'(s[i].a) : longint'(s[i].a);
               lb += (i < 4) ? 4 * longint'(s[i].b) : longint'(s[i].b);
            end
            react = ca * cb * cb;
            na = ca * den + longint'(diff_a_q) * la * 32768 - 20 * react
                 + 20 * f * (32768 - ca) * 32768;
            nb = cb * den + longint'(diff_b_q) * lb * 32768 + 20 * react
                 - 20 * (k + f) * cb * 32768;
            ra = settle(na, den);
            rb = settle(nb, den);
            grid_next[y * WIDTH + x] = '{b: rb, a: ra};
            if (rb > thresh_q) act++;
            total += rb;
         end
      grid_live = grid_next;
      active_q = act[13:0];
      bsum_q = total[28:0];
   endtask

   task automatic predict(req_type r);
      rsp_type  e;
      cell_type c, v;
      int       dx, dy, rr;
      e = '0;
      case (r.command)
         CMD_INJECT: begin
            v = r.erase ? CELL_INIT : '{b: Q15_ONE, a: SEED_A};
            rr = r.radius;
            for (dy = -rr; dy <= rr; dy++)
               for (dx = -rr; dx <= rr; dx++)
                  if (dx * dx + dy * dy <= rr * rr)
                     grid_live[cell_at(r.x_coord + dx, r.y_coord + dy)] = v;
         end
         CMD_STEP: run_generation();
         CMD_READ: begin
            c = grid_live[cell_at(r.x_coord, r.y_coord)];
            e.cell_a = c.a;
            e.cell_b = c.b;
         end
         default: ;
      endcase
      e.active_count = active_q;
      e.b_sum = bsum_q;
      expected_rsp.push_back(e);
   endtask

   // Random gap length: mostly short, now and then long.
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one transaction, predict at acceptance.
   task automatic send_req(req_type r);
      int g;
      g = gap_len();
      // valid drops at the previous falling edge, so start at a later falling edge
      repeat (g + 1) @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict(r);
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   function automatic req_type make_req(logic [1:0] cmd, int x, int y, int rad, bit er);
      req_type r;
      r.command = cmd;
      r.x_coord = x[6:0];
      r.y_coord = y[5:0];
      r.radius = rad[3:0];
      r.erase = er;
      return r;
   endfunction

   // Register write, only while nothing is pending.
   task automatic write_csr(logic [2:0] idx, logic [15:0] val);
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_FEED:      feed_q = val;
         CSR_KILL:      kill_q = val;
         CSR_DIFF_A:    diff_a_q = val;
         CSR_DIFF_B:    diff_b_q = val;
         CSR_THRESHOLD: thresh_q = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Result checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction %p", rsp_data);
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_data.cell_a !== e.cell_a || rsp_data.cell_b !== e.cell_b ||
                rsp_data.active_count !== e.active_count || rsp_data.b_sum !== e.b_sum) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p got %p", e, rsp_data);
            end
         end
      end
   end

   // Receiver stall: random gaps, plus forced hold-off.
   always @(negedge clock) begin
      if (hold_rsp) rsp_stall <= 1'b1;
      else if (stim_done) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < 25);
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("testbench: errors");
         $finish;
      end
   end

   task automatic test_directed_edges();
      send_req(make_req(CMD_READ, 0, 0, 0, 0));
      send_req(make_req(CMD_STEP, 0, 0, 0, 0));
      send_req(make_req(CMD_INJECT, 64, 32, 3, 0));
      send_req(make_req(CMD_INJECT, 0, 0, 15, 0));          // wraps around corner
      send_req(make_req(CMD_INJECT, 127, 63, 0, 0));
      send_req(make_req(CMD_READ, 127, 63, 0, 0));
      send_req(make_req(CMD_READ, 0, 0, 0, 0));
      send_req(make_req(CMD_READ, 66, 33, 0, 0));
      send_req(make_req(CMD_UNKNOWN, 127, 63, 15, 1));
      send_req(make_req(CMD_STEP, 127, 63, 15, 1));
      send_req(make_req(CMD_READ, 1, 63, 0, 0));
      send_req(make_req(CMD_INJECT, 64, 32, 2, 1));         // erase part
      send_req(make_req(CMD_READ, 64, 32, 0, 0));
      send_req(make_req(CMD_STEP, 0, 0, 0, 0));
      send_req(make_req(CMD_READ, 62, 31, 0, 1));
   endtask

   task automatic test_register_extremes();
      write_csr(CSR_FEED, 16'd32768);
      write_csr(CSR_KILL, 16'd0);
      write_csr(CSR_DIFF_A, 16'd0);
      write_csr(CSR_DIFF_B, 16'd32768);
      write_csr(CSR_THRESHOLD, 16'd0);
      send_req(make_req(CMD_STEP, 0, 0, 0, 0));
      send_req(make_req(CMD_READ, 5, 5, 0, 0));
      write_csr(CSR_FEED, 16'd0);
      write_csr(CSR_KILL, 16'hFFFF);                       // above one, still saturates
      write_csr(CSR_THRESHOLD, 16'hFFFF);
      send_req(make_req(CMD_INJECT, 10, 10, 5, 0));
      send_req(make_req(CMD_STEP, 0, 0, 0, 0));
      write_csr(CSR_FEED, 16'd1802);
      write_csr(CSR_KILL, 16'd2032);
      write_csr(CSR_DIFF_A, 16'd32768);
      write_csr(CSR_DIFF_B, 16'd16384);
      write_csr(CSR_THRESHOLD, 16'd3932);
   endtask

   // Receiver held off while the sender keeps offering reads.
   task automatic test_backpressure();
      int k;
      fork
         begin
            hold_rsp = 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (k = 0; k < 12; k++)
            send_req(make_req(CMD_READ, $urandom_range(0, 127), $urandom_range(0, 63), 0, 0));
      join
   endtask

   // Random mix: mostly injects and reads, a few generations (each sweeps the grid).
   task automatic test_random_mix();
      int k, p;
      req_type r;
      for (k = 0; k < 70; k++) begin
         p = $urandom_range(0, 99);
         r = make_req(CMD_READ, $urandom_range(0, 127), $urandom_range(0, 63),
                      $urandom_range(0, 15), $urandom_range(0, 1));
         if (p < 40) begin
            r.command = CMD_INJECT;
            if ($urandom_range(0, 9) != 0) r.radius = $urandom_range(0, 6);
         end else if (p < 50) r.command = CMD_STEP;
         else if (p < 53) r.command = CMD_UNKNOWN;
         send_req(r);
      end
   endtask

   initial begin
      feed_q = FEED_RESET; kill_q = KILL_RESET;
      diff_a_q = DIFF_A_RESET; diff_b_q = DIFF_B_RESET; thresh_q = THRESHOLD_RESET;
      active_q = '0; bsum_q = '0;
      foreach (grid_live[i]) grid_live[i] = CELL_INIT;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_edges();
      test_register_extremes();
      test_backpressure();
      test_random_mix();
      stim_done = 1'b1;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_rsp.size() == 0) $display("testbench: clean");
      else $display("testbench: errors");
      $finish;
   end

endmodule
